FILE: rtl/sha256_pkg.sv
// shared types, constants and round functions of the sha-256 digest unit
`timescale 1ns / 1ps
`default_nettype none

package sha256_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] hash_t;

  typedef struct packed {
    logic       shift_byte;
    logic [7:0] byte_val;
    logic       start;
    logic       hash_init;
  } core_ctrl_t;

  localparam hash_t HashInit = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [7:0] PadMarker = 8'h80;
  localparam logic [5:0] LenStart  = 6'd56;
  localparam logic [5:0] LastPos   = 6'd63;
  localparam logic [2:0] LastWord  = 3'd7;

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t ror32(input word_t x, input int unsigned n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sig0(input word_t x);
    big_sig0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic word_t big_sig1(input word_t x);
    big_sig1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

  function automatic word_t small_sig0(input word_t x);
    small_sig0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sig1(input word_t x);
    small_sig1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sha256_if.sv
// valid/ready channel interfaces for message bytes and digest words
`timescale 1ns / 1ps
`default_nettype none

interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] message_byte;
  logic       byte_present;
  logic       message_end;

  modport source (output valid, output message_byte, output byte_present,
                  output message_end, input ready);
  modport sink (input valid, input message_byte, input byte_present,
                input message_end, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink (input valid, input digest_word, input word_index,
                input last_word, output ready);
endinterface

`default_nettype wire

FILE: rtl/sha256_core.sv
// sha-256 compression engine: block window, one round per cycle, chaining hash
`timescale 1ns / 1ps
`default_nettype none

module sha256_core (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  sha256_pkg::core_ctrl_t  ctrl_i,
  output logic                    done_o,
  output sha256_pkg::hash_t       hash_o
);
  import sha256_pkg::*;

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_ADD} cstate_e;

  cstate_e      state_q, state_d;
  logic [5:0]   round_q, round_d;
  logic [511:0] blk_q, blk_d;
  hash_t        chain_q, chain_d;
  hash_t        wv_q, wv_d;

  word_t w0, w1, w9, w14, w_new, t1, t2;

  // window taps: word j of the block sits at bits [511-32j -: 32]
  assign w0  = blk_q[511:480];
  assign w1  = blk_q[479:448];
  assign w9  = blk_q[223:192];
  assign w14 = blk_q[63:32];
  assign w_new = small_sig1(w14) + w9 + small_sig0(w1) + w0;

  assign t1 = wv_q[7] + big_sig1(wv_q[4])
            + ((wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]))
            + RoundK[round_q] + w0;
  assign t2 = big_sig0(wv_q[0])
            + ((wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]));

  always_comb begin
    state_d = state_q;
    round_d = round_q;
    blk_d   = blk_q;
    chain_d = chain_q;
    wv_d    = wv_q;
    case (state_q)
      C_IDLE: begin
        if (ctrl_i.shift_byte) begin
          blk_d = {blk_q[503:0], ctrl_i.byte_val};
        end
        if (ctrl_i.hash_init) begin
          chain_d = HashInit;
        end
        if (ctrl_i.start) begin
          wv_d    = chain_q;
          round_d = '0;
          state_d = C_RUN;
        end
      end
      C_RUN: begin
        blk_d = {blk_q[479:0], w_new};
        wv_d  = {wv_q[6:4], wv_q[3] + t1, wv_q[2:0], t1 + t2};
        round_d = round_q + 6'd1;
        if (round_q == LastPos) begin
          state_d = C_ADD;
        end
      end
      C_ADD: begin
        for (int i = 0; i < 8; i++) begin
          chain_d[i] = chain_q[i] + wv_q[i];
        end
        state_d = C_IDLE;
      end
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      round_q <= '0;
      chain_q <= HashInit;
      wv_q    <= '0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      chain_q <= chain_d;
      wv_q    <= wv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
  end

  assign done_o = (state_q == C_ADD);
  assign hash_o = chain_q;

endmodule

`default_nettype wire

FILE: rtl/sha256_message_digest_unit.sv
// top level of the sha-256 digest unit: byte intake, padding sequencer, digest output
// intake: a byte that does not fill a block is shifted in and the unit stays ready;
//   the 64th byte of a block starts a compression (a load, 64 rounds, a chain add)
// message end: one pad byte per cycle up to the block end, the last one loading the
//   core, then 64 rounds and a chain add per compressed block (one or two), then
//   8 digest words at one per cycle while the receiver is ready
// throughput: one byte per cycle between blocks; input waits while the single round unit runs
// reset: chaining hash to the initial values, counters and flags cleared, ready to take bytes
`timescale 1ns / 1ps
`default_nettype none

module sha256_message_digest_unit (
  input  wire              clk_i,
  input  wire              rst_ni,
  sha256_in_if.sink        in_i,
  sha256_out_if.source     out_o
);
  import sha256_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_COMP, S_PAD, S_OUT} state_e;

  state_e      state_q, state_d;
  logic [5:0]  pos_q, pos_d;         // bytes held in the current block
  logic [63:0] bitcnt_q, bitcnt_d;   // message length in bits, wraps
  logic        pend_end_q, pend_end_d;   // message ends after the running block
  logic        pad_act_q, pad_act_d;     // padding in progress
  logic        pad_first_q, pad_first_d; // next pad byte is the 0x80 marker
  logic        fin_q, fin_d;             // current block carries the length
  logic [2:0]  widx_q, widx_d;

  core_ctrl_t  ctrl;
  logic        core_done;
  hash_t       hash;
  logic        in_acc, out_acc;
  logic [7:0]  pad_byte;
  logic [5:0]  len_sel;

  sha256_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .done_o (core_done),
    .hash_o (hash)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  assign out_o.valid       = (state_q == S_OUT);
  assign out_o.digest_word = hash[widx_q];
  assign out_o.word_index  = widx_q;
  assign out_o.last_word   = (widx_q == LastWord);
  assign out_acc           = out_o.valid && out_o.ready;

  // length bytes go out most significant first at positions 56..63
  assign len_sel  = {~pos_q[2:0], 3'b000};
  assign pad_byte = pad_first_q ? PadMarker :
                    (fin_q && (pos_q >= LenStart)) ? bitcnt_q[len_sel +: 8] : 8'h00;

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    bitcnt_d    = bitcnt_q;
    pend_end_d  = pend_end_q;
    pad_act_d   = pad_act_q;
    pad_first_d = pad_first_q;
    fin_d       = fin_q;
    widx_d      = widx_q;
    ctrl        = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_i.byte_present) begin
            ctrl.shift_byte = 1'b1;
            ctrl.byte_val   = in_i.message_byte;
            pos_d    = pos_q + 6'd1;
            bitcnt_d = bitcnt_q + 64'd8;
          end
          if (in_i.byte_present && (pos_q == LastPos)) begin
            // block full: compress first, pad afterwards if the message ends
            ctrl.start = 1'b1;
            pend_end_d = in_i.message_end;
            state_d    = S_COMP;
          end else if (in_i.message_end) begin
            pad_act_d   = 1'b1;
            pad_first_d = 1'b1;
            state_d     = S_PAD;
          end
        end
      end
      S_PAD: begin
        ctrl.shift_byte = 1'b1;
        ctrl.byte_val   = pad_byte;
        pos_d       = pos_q + 6'd1;
        pad_first_d = 1'b0;
        if (pad_first_q) begin
          // marker past position 55 leaves no room for the length here
          fin_d = (pos_q < LenStart);
        end
        if (pos_q == LastPos) begin
          ctrl.start = 1'b1;
          state_d    = S_COMP;
        end
      end
      S_COMP: begin
        if (core_done) begin
          if (fin_q) begin
            widx_d  = '0;
            state_d = S_OUT;
          end else if (pend_end_q) begin
            pend_end_d  = 1'b0;
            pad_act_d   = 1'b1;
            pad_first_d = 1'b1;
            state_d     = S_PAD;
          end else if (pad_act_q) begin
            fin_d   = 1'b1;
            state_d = S_PAD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_OUT: begin
        if (out_acc) begin
          widx_d = widx_q + 3'd1;
          if (widx_q == LastWord) begin
            // back to the initial state for the next message
            ctrl.hash_init = 1'b1;
            pos_d      = '0;
            bitcnt_d   = '0;
            pend_end_d = 1'b0;
            pad_act_d  = 1'b0;
            fin_d      = 1'b0;
            state_d    = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      bitcnt_q    <= '0;
      pend_end_q  <= 1'b0;
      pad_act_q   <= 1'b0;
      pad_first_q <= 1'b0;
      fin_q       <= 1'b0;
      widx_q      <= '0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      bitcnt_q    <= bitcnt_d;
      pend_end_q  <= pend_end_d;
      pad_act_q   <= pad_act_d;
      pad_first_q <= pad_first_d;
      fin_q       <= fin_d;
      widx_q      <= widx_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sha256_checker.sv
// port-level checks of the sha-256 digest unit and their binding
`timescale 1ns / 1ps
`default_nettype none

module sha256_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_ready_i,
  input wire        in_end_i,
  input wire        out_valid_i,
  input wire        out_ready_i,
  input wire [2:0]  out_index_i,
  input wire        out_last_i
);

  wire in_acc  = in_valid_i && in_ready_i;
  wire out_acc = out_valid_i && out_ready_i;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input taken while digest is being delivered");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_last_i == (out_index_i == 3'd7)))
    else $error("last_word does not match word_index");

  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !out_last_i) |=>
      (out_valid_i && (out_index_i == $past(out_index_i) + 3'd1)))
    else $error("digest words not delivered in order");

  a_end_of_digest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_last_i) |=> (!out_valid_i && in_ready_i))
    else $error("unit not idle after last digest word");

  a_no_early_digest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !in_end_i) |=> !out_valid_i)
    else $error("digest without message end");

endmodule

bind sha256_message_digest_unit sha256_checker u_sha256_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_end_i    (in_i.message_end),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_index_i (out_o.word_index),
  .out_last_i  (out_o.last_word)
);

`default_nettype wire
